[rtl/paik_pkg.sv]
// Shared constants, register codes and elaboration-time helpers for the
// parallel-arm inverse kinematics block. No dependencies.
package paik_pkg;

	localparam int TGT_W      = 32;
	localparam int LEN_W      = 31;
	localparam int ANGLE_W    = 25;
	localparam int ARM_IDX_W  = 3;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;
	localparam int MAX_ARMS   = 8;
	localparam int NUM_ARMS_DEF = 3;
	localparam int CORDIC_N   = 28;

	localparam longint Q24_90   = 64'sd1509949440;
	localparam longint Q24_180  = 64'sd3019898880;
	localparam longint Q24_360  = 64'sd6039797760;
	localparam longint CORDIC_K = 64'sd652032874;
	localparam longint ANGLE_MAX = 64'sd11796480;

	localparam logic [LEN_W-1:0] ARM_LENGTH_RST      = 31'd6553600;
	localparam logic [LEN_W-1:0] ROD_LENGTH_RST      = 31'd13107200;
	localparam logic [LEN_W-1:0] BASE_RADIUS_RST     = 31'd5242880;
	localparam logic [LEN_W-1:0] EFFECTOR_RADIUS_RST = 31'd1966080;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ARM_LENGTH      = 2'd0,
		REG_ROD_LENGTH      = 2'd1,
		REG_BASE_RADIUS     = 2'd2,
		REG_EFFECTOR_RADIUS = 2'd3
	} cfg_reg_t;

	// atan(2^-i) in Q8.24 degrees.
	function automatic longint atan_q24(input int i);
		longint v;
		case (i)
			0: v = 754974720;
			1: v = 445687602;
			2: v = 235489088;
			3: v = 119537938;
			4: v = 60000934;
			5: v = 30029717;
			6: v = 15018523;
			7: v = 7509720;
			8: v = 3754917;
			9: v = 1877466;
			10: v = 938734;
			11: v = 469367;
			12: v = 234684;
			13: v = 117342;
			14: v = 58671;
			15: v = 29335;
			16: v = 14668;
			17: v = 7334;
			18: v = 3667;
			19: v = 1833;
			20: v = 917;
			21: v = 458;
			22: v = 229;
			23: v = 115;
			24: v = 57;
			25: v = 29;
			26: v = 14;
			27: v = 7;
			default: v = 0;
		endcase
		return v;
	endfunction

	// Rotation CORDIC for a fixed arm angle, evaluated at elaboration.
	// Returns {cos, sin} in Q1.30.
	function automatic logic [63:0] arm_rot(input longint ang);
		longint x;
		longint y;
		longint t;
		longint a;
		a = ang;
		if (a > Q24_90) begin
			x = 0;
			y = CORDIC_K;
			a = a - Q24_90;
		end else if (a < -Q24_90) begin
			x = 0;
			y = -CORDIC_K;
			a = a + Q24_90;
		end else begin
			x = CORDIC_K;
			y = 0;
		end
		for (int i = 0; i < CORDIC_N; i++) begin
			t = x;
			if (a >= 0) begin
				x = x - (y >>> i);
				y = y + (t >>> i);
				a = a - atan_q24(i);
			end else begin
				x = x + (y >>> i);
				y = y - (t >>> i);
				a = a + atan_q24(i);
			end
		end
		return {x[31:0], y[31:0]};
	endfunction

endpackage

[rtl/parallel_arm_inverse_kinematics.sv]
// Top level of the parallel-arm inverse kinematics block: arm sequencer and
// the full arithmetic pipeline. Depends on paik_pkg.

// One target beat in gives NUM_ARMS result beats out, arms in ascending order,
// the final one flagged by last. A new target is taken when idle or as the last
// arm of the previous one is issued; one arm result comes per cycle while the
// output is not stalled, because the arm sequencer feeds one arm into the
// pipeline each cycle that it advances. The pipeline is fully registered; the
// long parts are the two bit-per-stage square roots, the bit-per-stage divider
// and the two side-by-side 28-stage vectoring CORDICs. A stalled output freezes
// the whole pipeline; the arm sequencer still takes one target while it waits.
// Configuration is written through the cfg port, which is always ready, and
// must only change while no target is in flight.
module parallel_arm_inverse_kinematics #(
	parameter int NUM_ARMS = paik_pkg::NUM_ARMS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic signed [paik_pkg::TGT_W-1:0] target_x,
	input  logic signed [paik_pkg::TGT_W-1:0] target_y,
	input  logic signed [paik_pkg::TGT_W-1:0] target_z,
	output logic out_valid,
	input  logic out_ready,
	output logic [paik_pkg::ARM_IDX_W-1:0] arm_index,
	output logic signed [paik_pkg::ANGLE_W-1:0] angle_deg,
	output logic reachable,
	output logic last,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [paik_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [paik_pkg::CFG_DATA_W-1:0] cfg_data
);
	import paik_pkg::*;

	localparam int N_ARMS = (NUM_ARMS > MAX_ARMS) ? MAX_ARMS : ((NUM_ARMS < 1) ? 1 : NUM_ARMS);
	localparam int CNT_W  = (N_ARMS > 1) ? $clog2(N_ARMS) : 1;
	localparam int SQ1_W  = 54;
	localparam int SQ1_N  = 27;
	localparam int SQ2_W  = 61;
	localparam int SQ2_N  = 31;
	localparam int DIV_N  = 31;
	localparam int LN_N   = 3 + CORDIC_N;

	typedef struct packed {
		logic [ARM_IDX_W-1:0] idx;
		logic                 last;
	} tag_t;

	typedef struct packed {
		tag_t               tag;
		logic signed [57:0] num;
		logic signed [37:0] proj;
		logic signed [31:0] tz;
	} c1_t;

	typedef struct packed {
		tag_t               tag;
		logic               ok;
		logic               neg;
		logic signed [37:0] proj;
		logic signed [31:0] tz;
		logic [51:0]        den;
	} c2_t;

	typedef struct packed {
		tag_t               tag;
		logic               ok;
		logic signed [37:0] proj;
		logic signed [31:0] tz;
		logic signed [31:0] c;
	} c3_t;

	typedef struct packed {
		tag_t tag;
		logic ok;
		logic pneg;
	} c5_t;

	typedef struct packed {
		logic signed [45:0] x;
		logic signed [45:0] y;
		logic [45:0]        m;
		logic signed [33:0] z;
		logic               zero;
	} lane_t;

	function automatic logic signed [37:0] rnd_q30(input logic signed [66:0] p);
		logic signed [66:0] t;
		t = p + (67'sd1 <<< 29);
		return 38'(t >>> 30);
	endfunction

	function automatic lane_t prep_lane(input logic signed [45:0] x0,
			input logic signed [45:0] y0);
		lane_t l;
		logic [45:0] ax;
		logic [45:0] ay;
		l.zero = (x0 == '0) && (y0 == '0);
		l.x = x0;
		l.y = y0;
		l.z = '0;
		// A vector in the left half plane is turned a quarter turn first.
		if (x0 < 0) begin
			if (y0 >= 0) begin
				l.x = y0;
				l.y = -x0;
				l.z = 34'(Q24_90);
			end else begin
				l.x = -y0;
				l.y = x0;
				l.z = -34'(Q24_90);
			end
		end
		ax = l.x[45] ? 46'(-l.x) : 46'(l.x);
		ay = l.y[45] ? 46'(-l.y) : 46'(l.y);
		l.m = (ax > ay) ? ax : ay;
		return l;
	endfunction

	function automatic lane_t norm_lane(input lane_t li, input int step);
		lane_t l;
		l = li;
		if (l.m < (46'd1 << (40 - step))) begin
			l.x = l.x <<< step;
			l.y = l.y <<< step;
			l.m = l.m << step;
		end
		return l;
	endfunction

	function automatic lane_t cordic_lane(input lane_t li, input int i);
		lane_t l;
		logic signed [45:0] xo;
		l = li;
		xo = l.x;
		if (!l.y[45]) begin
			l.x = l.x + (l.y >>> i);
			l.y = l.y - (xo >>> i);
			l.z = l.z + 34'(atan_q24(i));
		end else begin
			l.x = l.x - (l.y >>> i);
			l.y = l.y + (xo >>> i);
			l.z = l.z - 34'(atan_q24(i));
		end
		return l;
	endfunction

	logic adv;

	// Configuration registers.
	logic [LEN_W-1:0] arm_q;
	logic [LEN_W-1:0] rod_q;
	logic [LEN_W-1:0] base_q;
	logic [LEN_W-1:0] eff_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			arm_q  <= ARM_LENGTH_RST;
			rod_q  <= ROD_LENGTH_RST;
			base_q <= BASE_RADIUS_RST;
			eff_q  <= EFFECTOR_RADIUS_RST;
		end else if (cfg_valid) begin
			case (cfg_reg_t'(cfg_index))
				REG_ARM_LENGTH:      arm_q  <= cfg_data[LEN_W-1:0];
				REG_ROD_LENGTH:      rod_q  <= cfg_data[LEN_W-1:0];
				REG_BASE_RADIUS:     base_q <= cfg_data[LEN_W-1:0];
				REG_EFFECTOR_RADIUS: eff_q  <= cfg_data[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// Arm direction table, worked out at elaboration.
	logic signed [31:0] arm_cos [N_ARMS];
	logic signed [31:0] arm_sin [N_ARMS];

	for (genvar g = 0; g < N_ARMS; g++) begin : g_arm
		localparam longint ANG_RAW = (Q24_360 * g) / N_ARMS;
		localparam longint ANG = (ANG_RAW > Q24_180) ? ANG_RAW - Q24_360 : ANG_RAW;
		localparam logic [63:0] ROT = arm_rot(ANG);
		assign arm_cos[g] = signed'(ROT[63:32]);
		assign arm_sin[g] = signed'(ROT[31:0]);
	end

	// Arm sequencer: holds one target and issues its arms one per cycle while the pipeline advances.
	logic               busy_q;
	logic [CNT_W-1:0]   cnt_q;
	logic signed [31:0] tx_q;
	logic signed [31:0] ty_q;
	logic signed [31:0] tz_q;
	logic               cnt_last;
	logic               in_acc;

	assign cnt_last = (cnt_q == CNT_W'(N_ARMS - 1));
	assign in_ready = !busy_q || (adv && cnt_last);
	assign in_acc   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (in_acc) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q && adv) begin
			if (cnt_last) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			tx_q <= target_x;
			ty_q <= target_y;
			tz_q <= target_z;
		end
	end

	// Stage 1: arm item.
	logic               vld_s1;
	tag_t               tag_s1;
	logic signed [31:0] tx_s1, ty_s1, tz_s1, cs_s1, sn_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= busy_q;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tag_s1.idx  <= ARM_IDX_W'(cnt_q);
			tag_s1.last <= cnt_last;
			tx_s1 <= tx_q;
			ty_s1 <= ty_q;
			tz_s1 <= tz_q;
			cs_s1 <= arm_cos[cnt_q];
			sn_s1 <= arm_sin[cnt_q];
		end
	end

	// Stage 2: radius times direction.
	logic               vld_s2;
	tag_t               tag_s2;
	logic signed [31:0] tx_s2, ty_s2, tz_s2, cs_s2, sn_s2;
	logic signed [63:0] pec_s2, pes_s2, pbc_s2, pbs_s2;
	logic signed [31:0] er, br;

	assign er = signed'({1'b0, eff_q});
	assign br = signed'({1'b0, base_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tag_s2 <= tag_s1;
			tx_s2  <= tx_s1;
			ty_s2  <= ty_s1;
			tz_s2  <= tz_s1;
			cs_s2  <= cs_s1;
			sn_s2  <= sn_s1;
			pec_s2 <= er * cs_s1;
			pes_s2 <= er * sn_s1;
			pbc_s2 <= br * cs_s1;
			pbs_s2 <= br * sn_s1;
		end
	end

	// Stage 3: round the products back to Q16.16.
	logic               vld_s3;
	tag_t               tag_s3;
	logic signed [31:0] tx_s3, ty_s3, tz_s3, cs_s3, sn_s3;
	logic signed [33:0] mec_s3, mes_s3, mbc_s3, mbs_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tag_s3 <= tag_s2;
			tx_s3  <= tx_s2;
			ty_s3  <= ty_s2;
			tz_s3  <= tz_s2;
			cs_s3  <= cs_s2;
			sn_s3  <= sn_s2;
			mec_s3 <= 34'(rnd_q30(67'(pec_s2)));
			mes_s3 <= 34'(rnd_q30(67'(pes_s2)));
			mbc_s3 <= 34'(rnd_q30(67'(pbc_s2)));
			mbs_s3 <= 34'(rnd_q30(67'(pbs_s2)));
		end
	end

	// Stage 4: effector joint and its offset from the base joint in Q.8.
	logic               vld_s4;
	tag_t               tag_s4;
	logic signed [31:0] tz_s4, cs_s4, sn_s4;
	logic signed [34:0] ex_s4, ey_s4;
	logic signed [27:0] dx_s4, dy_s4;
	logic signed [23:0] dz_s4;
	logic signed [35:0] ddx, ddy;

	assign ddx = 36'(tx_s3) + 36'(mec_s3) - 36'(mbc_s3);
	assign ddy = 36'(ty_s3) + 36'(mes_s3) - 36'(mbs_s3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (adv) begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tag_s4 <= tag_s3;
			tz_s4  <= tz_s3;
			cs_s4  <= cs_s3;
			sn_s4  <= sn_s3;
			ex_s4  <= 35'(tx_s3) + 35'(mec_s3);
			ey_s4  <= 35'(ty_s3) + 35'(mes_s3);
			dx_s4  <= signed'(ddx[35:8]);
			dy_s4  <= signed'(ddy[35:8]);
			dz_s4  <= signed'(tz_s3[31:8]);
		end
	end

	// Stage 5: squares and projection products.
	logic               vld_s5;
	tag_t               tag_s5;
	logic signed [31:0] tz_s5;
	logic signed [55:0] dx2_s5, dy2_s5;
	logic signed [47:0] dz2_s5;
	logic signed [66:0] pxc_s5, pys_s5;
	logic [45:0]        l2sq_s5, l3sq_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else if (adv) begin
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tag_s5  <= tag_s4;
			tz_s5   <= tz_s4;
			dx2_s5  <= dx_s4 * dx_s4;
			dy2_s5  <= dy_s4 * dy_s4;
			dz2_s5  <= dz_s4 * dz_s4;
			pxc_s5  <= 67'(ex_s4) * 67'(cs_s4);
			pys_s5  <= 67'(ey_s4) * 67'(sn_s4);
			l2sq_s5 <= arm_q[30:8] * arm_q[30:8];
			l3sq_s5 <= rod_q[30:8] * rod_q[30:8];
		end
	end

	// Stage 6: squared distance, length term and projection.
	logic               vld_s6;
	tag_t               tag_s6;
	logic signed [31:0] tz_s6;
	logic [SQ1_W-1:0]   sq_s6;
	logic signed [46:0] nump_s6;
	logic signed [37:0] proj_s6;
	logic signed [55:0] sq_sum;

	assign sq_sum = dx2_s5 + dy2_s5 + 56'(dz2_s5);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else if (adv) begin
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tag_s6  <= tag_s5;
			tz_s6   <= tz_s5;
			sq_s6   <= SQ1_W'(sq_sum);
			nump_s6 <= signed'({1'b0, l2sq_s5}) - signed'({1'b0, l3sq_s5});
			proj_s6 <= rnd_q30(pxc_s5) + rnd_q30(pys_s5);
		end
	end

	// Distance square root, one result bit per stage.
	logic             sq1_vld_s [0:SQ1_N];
	logic [SQ1_W-1:0] sq1_v_s   [0:SQ1_N];
	logic [SQ1_W:0]   sq1_r_s   [0:SQ1_N];
	c1_t              sq1_c_s   [0:SQ1_N];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq1_vld_s[0] <= 1'b0;
		end else if (adv) begin
			sq1_vld_s[0] <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sq1_v_s[0]      <= sq_s6;
			sq1_r_s[0]      <= '0;
			sq1_c_s[0].tag  <= tag_s6;
			sq1_c_s[0].num  <= signed'({4'b0, sq_s6}) + 58'(nump_s6);
			sq1_c_s[0].proj <= proj_s6;
			sq1_c_s[0].tz   <= tz_s6;
		end
	end

	for (genvar k = 0; k < SQ1_N; k++) begin : g_sq1
		localparam logic [SQ1_W:0] BIT = (SQ1_W + 1)'(1) << (2 * (SQ1_N - 1 - k));
		logic [SQ1_W:0] trial;
		logic           ge;

		assign trial = sq1_r_s[k] + BIT;
		assign ge    = ({1'b0, sq1_v_s[k]} >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq1_vld_s[k+1] <= 1'b0;
			end else if (adv) begin
				sq1_vld_s[k+1] <= sq1_vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				sq1_c_s[k+1] <= sq1_c_s[k];
				if (ge) begin
					sq1_v_s[k+1] <= SQ1_W'({1'b0, sq1_v_s[k]} - trial);
					sq1_r_s[k+1] <= (sq1_r_s[k] >> 1) + BIT;
				end else begin
					sq1_v_s[k+1] <= sq1_v_s[k];
					sq1_r_s[k+1] <= sq1_r_s[k] >> 1;
				end
			end
		end
	end

	// Denominator 2*d*arm.
	logic        vld_sd;
	c1_t         c_sd;
	logic [51:0] den_sd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sd <= 1'b0;
		end else if (adv) begin
			vld_sd <= sq1_vld_s[SQ1_N];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			c_sd   <= sq1_c_s[SQ1_N];
			den_sd <= {51'(sq1_r_s[SQ1_N][26:0]) * 51'(arm_q[30:8]), 1'b0};
		end
	end

	// Restoring divider for the acos argument, one quotient bit per stage.
	logic        dv_vld_s [0:DIV_N];
	logic [52:0] dv_r_s   [0:DIV_N];
	logic [30:0] dv_q_s   [0:DIV_N];
	c2_t         dv_c_s   [0:DIV_N];
	logic [57:0] nabs;

	assign nabs = c_sd.num[57] ? 58'(-c_sd.num) : 58'(c_sd.num);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_vld_s[0] <= 1'b0;
		end else if (adv) begin
			dv_vld_s[0] <= vld_sd;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dv_r_s[0]      <= nabs[52:0];
			dv_q_s[0]      <= '0;
			dv_c_s[0].tag  <= c_sd.tag;
			dv_c_s[0].ok   <= (den_sd != '0) && (nabs <= {6'b0, den_sd});
			dv_c_s[0].neg  <= c_sd.num[57];
			dv_c_s[0].proj <= c_sd.proj;
			dv_c_s[0].tz   <= c_sd.tz;
			dv_c_s[0].den  <= den_sd;
		end
	end

	for (genvar k = 0; k < DIV_N; k++) begin : g_div
		logic [52:0] rin;
		logic        ge;

		if (k == 0) begin : g_first
			assign rin = dv_r_s[k];
		end else begin : g_next
			assign rin = {dv_r_s[k][51:0], 1'b0};
		end
		assign ge = (rin >= {1'b0, dv_c_s[k].den});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_vld_s[k+1] <= 1'b0;
			end else if (adv) begin
				dv_vld_s[k+1] <= dv_vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				dv_c_s[k+1] <= dv_c_s[k];
				dv_q_s[k+1] <= {dv_q_s[k][29:0], ge};
				dv_r_s[k+1] <= ge ? rin - {1'b0, dv_c_s[k].den} : rin;
			end
		end
	end

	// Signed acos argument and its square.
	logic        vld_sc;
	c3_t         c_sc;
	logic [61:0] csq_sc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sc <= 1'b0;
		end else if (adv) begin
			vld_sc <= dv_vld_s[DIV_N];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			c_sc.tag  <= dv_c_s[DIV_N].tag;
			c_sc.ok   <= dv_c_s[DIV_N].ok;
			c_sc.proj <= dv_c_s[DIV_N].proj;
			c_sc.tz   <= dv_c_s[DIV_N].tz;
			c_sc.c    <= dv_c_s[DIV_N].neg ? -signed'({1'b0, dv_q_s[DIV_N]})
				: signed'({1'b0, dv_q_s[DIV_N]});
			csq_sc    <= dv_q_s[DIV_N] * dv_q_s[DIV_N];
		end
	end

	// Square root of 1 - c^2 in Q1.30 terms.
	logic             sq2_vld_s [0:SQ2_N];
	logic [SQ2_W-1:0] sq2_v_s   [0:SQ2_N];
	logic [SQ2_W:0]   sq2_r_s   [0:SQ2_N];
	c3_t              sq2_c_s   [0:SQ2_N];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq2_vld_s[0] <= 1'b0;
		end else if (adv) begin
			sq2_vld_s[0] <= vld_sc;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sq2_v_s[0] <= (SQ2_W'(1) << 60) - csq_sc[SQ2_W-1:0];
			sq2_r_s[0] <= '0;
			sq2_c_s[0] <= c_sc;
		end
	end

	for (genvar k = 0; k < SQ2_N; k++) begin : g_sq2
		localparam logic [SQ2_W:0] BIT = (SQ2_W + 1)'(1) << (2 * (SQ2_N - 1 - k));
		logic [SQ2_W:0] trial;
		logic           ge;

		assign trial = sq2_r_s[k] + BIT;
		assign ge    = ({1'b0, sq2_v_s[k]} >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq2_vld_s[k+1] <= 1'b0;
			end else if (adv) begin
				sq2_vld_s[k+1] <= sq2_vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				sq2_c_s[k+1] <= sq2_c_s[k];
				if (ge) begin
					sq2_v_s[k+1] <= SQ2_W'({1'b0, sq2_v_s[k]} - trial);
					sq2_r_s[k+1] <= (sq2_r_s[k] >> 1) + BIT;
				end else begin
					sq2_v_s[k+1] <= sq2_v_s[k];
					sq2_r_s[k+1] <= sq2_r_s[k] >> 1;
				end
			end
		end
	end

	// Two atan2 lanes side by side: lane A gives the elevation, lane B the
	// acos term. Three normalizing stages, then the vectoring iterations.
	logic               ln_vld_s [0:LN_N];
	lane_t              lna_s    [0:LN_N];
	lane_t              lnb_s    [0:LN_N];
	c5_t                ln_c_s   [0:LN_N];
	logic signed [37:0] pabs;

	assign pabs = sq2_c_s[SQ2_N].proj[37] ? -sq2_c_s[SQ2_N].proj : sq2_c_s[SQ2_N].proj;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ln_vld_s[0] <= 1'b0;
		end else if (adv) begin
			ln_vld_s[0] <= sq2_vld_s[SQ2_N];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			lna_s[0]       <= prep_lane(46'(pabs), 46'(sq2_c_s[SQ2_N].tz));
			lnb_s[0]       <= prep_lane(46'(sq2_c_s[SQ2_N].c),
				signed'({15'b0, sq2_r_s[SQ2_N][30:0]}));
			ln_c_s[0].tag  <= sq2_c_s[SQ2_N].tag;
			ln_c_s[0].ok   <= sq2_c_s[SQ2_N].ok;
			ln_c_s[0].pneg <= sq2_c_s[SQ2_N].proj[37];
		end
	end

	for (genvar k = 0; k < LN_N; k++) begin : g_lane
		lane_t na;
		lane_t nb;

		if (k == 0) begin : g_n0
			assign na = norm_lane(norm_lane(lna_s[k], 32), 16);
			assign nb = norm_lane(norm_lane(lnb_s[k], 32), 16);
		end else if (k == 1) begin : g_n1
			assign na = norm_lane(norm_lane(lna_s[k], 8), 4);
			assign nb = norm_lane(norm_lane(lnb_s[k], 8), 4);
		end else if (k == 2) begin : g_n2
			// One doubling past the largest shift that stays below 2^40.
			lane_t ta;
			lane_t tb;
			always_comb begin
				ta = norm_lane(norm_lane(lna_s[k], 2), 1);
				tb = norm_lane(norm_lane(lnb_s[k], 2), 1);
				ta.x = ta.x <<< 1;
				ta.y = ta.y <<< 1;
				ta.m = ta.m << 1;
				tb.x = tb.x <<< 1;
				tb.y = tb.y <<< 1;
				tb.m = tb.m << 1;
			end
			assign na = ta;
			assign nb = tb;
		end else begin : g_rot
			assign na = cordic_lane(lna_s[k], k - 3);
			assign nb = cordic_lane(lnb_s[k], k - 3);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ln_vld_s[k+1] <= 1'b0;
			end else if (adv) begin
				ln_vld_s[k+1] <= ln_vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				lna_s[k+1]  <= na;
				lnb_s[k+1]  <= nb;
				ln_c_s[k+1] <= ln_c_s[k];
			end
		end
	end

	// Elevation minus acos term, Q8.24.
	logic               vld_sf;
	c5_t                c_sf;
	logic signed [35:0] elev_sf;
	logic signed [33:0] za, zb;

	assign za = lna_s[LN_N].zero ? '0 : lna_s[LN_N].z;
	assign zb = lnb_s[LN_N].zero ? '0 : lnb_s[LN_N].z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sf <= 1'b0;
		end else if (adv) begin
			vld_sf <= ln_vld_s[LN_N];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			c_sf    <= ln_c_s[LN_N];
			elev_sf <= 36'(za) + (ln_c_s[LN_N].pneg ? 36'(Q24_90) : 36'sd0) - 36'(zb);
		end
	end

	// Output register: round to Q9.16 and saturate.
	logic                      out_vld_q;
	tag_t                      out_tag_q;
	logic signed [ANGLE_W-1:0] out_ang_q;
	logic                      out_ok_q;
	logic signed [35:0]        ang_r;

	assign ang_r = (elev_sf + 36'sd128) >>> 8;
	assign adv   = !out_vld_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= vld_sf;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_tag_q <= c_sf.tag;
			out_ok_q  <= c_sf.ok;
			if (!c_sf.ok) begin
				out_ang_q <= '0;
			end else if (ang_r > 36'(ANGLE_MAX)) begin
				out_ang_q <= ANGLE_W'(ANGLE_MAX);
			end else if (ang_r < -36'(ANGLE_MAX)) begin
				out_ang_q <= -ANGLE_W'(ANGLE_MAX);
			end else begin
				out_ang_q <= ANGLE_W'(ang_r);
			end
		end
	end

	assign out_valid = out_vld_q;
	assign arm_index = out_tag_q.idx;
	assign last      = out_tag_q.last;
	assign angle_deg = out_ang_q;
	assign reachable = out_ok_q;

endmodule

[tb/sv/parallel_arm_inverse_kinematics_test.sv]
`timescale 1ns / 100ps
// Testbench for parallel_arm_inverse_kinematics: drives targets and geometry registers,
// predicts every arm angle with its own fixed-point solver and checks each result beat.
// Depends on paik_pkg and the block's RTL.
module parallel_arm_inverse_kinematics_test;
	import paik_pkg::*;

	localparam int ARMS = NUM_ARMS_DEF;
	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE_CYCLES = 250;
	localparam int HOLD_CYCLES = 400;
	localparam longint ATAN_TBL [0:27] = '{
		754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
		15018523, 7509720, 3754917, 1877466, 938734, 469367, 234684, 117342,
		58671, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7
	};

	typedef struct packed {
		logic [ARM_IDX_W-1:0] arm;
		logic signed [ANGLE_W-1:0] angle;
		logic reach;
		logic final_arm;
	} arm_result_t;

	typedef struct {
		logic signed [TGT_W-1:0] x;
		logic signed [TGT_W-1:0] y;
		logic signed [TGT_W-1:0] z;
		bit out_of_reach;
	} target_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [TGT_W-1:0] target_x = '0;
	logic signed [TGT_W-1:0] target_y = '0;
	logic signed [TGT_W-1:0] target_z = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [ARM_IDX_W-1:0] arm_index;
	logic signed [ANGLE_W-1:0] angle_deg;
	logic reachable;
	logic last;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	arm_result_t pending_angles[$];
	logic [LEN_W-1:0] arm_len = ARM_LENGTH_RST;
	logic [LEN_W-1:0] rod_len = ROD_LENGTH_RST;
	logic [LEN_W-1:0] base_rad = BASE_RADIUS_RST;
	logic [LEN_W-1:0] eff_rad = EFFECTOR_RADIUS_RST;
	int fails = 0;
	int cycles = 0;
	int hold_requests = 0;
	bit quiet = 1'b0;

	parallel_arm_inverse_kinematics dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.target_x(target_x), .target_y(target_y), .target_z(target_z),
		.out_valid(out_valid), .out_ready(out_ready),
		.arm_index(arm_index), .angle_deg(angle_deg), .reachable(reachable), .last(last),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("parallel_arm_inverse_kinematics verification failed");
			$finish;
		end
	end

	function automatic longint mul_q30(input longint a, input longint c);
		return (a * c + (longint'(1) <<< 29)) >>> 30;
	endfunction

	function automatic longint int_sqrt(input bit [63:0] v);
		bit [63:0] r = '0;
		bit [63:0] b = 64'h4000_0000_0000_0000;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return longint'(r);
	endfunction

	// Unit direction of an arm, Q1.30, by rotation CORDIC from the fixed gain vector.
	function automatic void arm_direction(input longint ang, output longint cs,
			output longint sn);
		longint x, y, t, a;
		a = ang;
		if (a > Q24_90) begin
			x = 0; y = CORDIC_K; a = a - Q24_90;
		end else if (a < -Q24_90) begin
			x = 0; y = -CORDIC_K; a = a + Q24_90;
		end else begin
			x = CORDIC_K; y = 0;
		end
		for (int i = 0; i < 28; i++) begin
			t = x;
			if (a >= 0) begin
				x = x - (y >>> i); y = y + (t >>> i); a = a - ATAN_TBL[i];
			end else begin
				x = x + (y >>> i); y = y - (t >>> i); a = a + ATAN_TBL[i];
			end
		end
		cs = x;
		sn = y;
	endfunction

	function automatic longint vector_angle(input longint y, input longint x);
		longint off, z, t;
		off = 0;
		z = 0;
		if (x == 0 && y == 0) return 0;
		if (x < 0) begin
			t = x;
			if (y >= 0) begin
				x = y; y = -t; off = Q24_90;
			end else begin
				x = -y; y = t; off = -Q24_90;
			end
		end
		while ((x < 0 ? -x : x) < (longint'(1) <<< 40) && (y < 0 ? -y : y) < (longint'(1) <<< 40))
		begin
			x = x * 2;
			y = y * 2;
		end
		for (int i = 0; i < 28; i++) begin
			t = x;
			if (y >= 0) begin
				x = x + (y >>> i); y = y - (t >>> i); z = z + ATAN_TBL[i];
			end else begin
				x = x - (y >>> i); y = y + (t >>> i); z = z - ATAN_TBL[i];
			end
		end
		return z + off;
	endfunction

	// Expected motor angle of every arm for one target under the current geometry.
	task automatic solve_arm_angles(input logic signed [TGT_W-1:0] tx_in,
			input logic signed [TGT_W-1:0] ty_in, input logic signed [TGT_W-1:0] tz_in);
		longint tx, ty, tz, a, cs, sn, ex, ey, dx, dy, dz, sq, joint_gap, l2, l3;
		longint num, den, nabs, q, r, c, proj, elev, ang;
		bit ok;
		arm_result_t res;
		tx = tx_in;
		ty = ty_in;
		tz = tz_in;
		l2 = longint'(arm_len) >>> 8;
		l3 = longint'(rod_len) >>> 8;
		for (int s = 0; s < ARMS; s++) begin
			a = (Q24_360 * s) / ARMS;
			if (a > Q24_180) a = a - Q24_360;
			arm_direction(a, cs, sn);
			ex = tx + mul_q30(longint'(eff_rad), cs);
			ey = ty + mul_q30(longint'(eff_rad), sn);
			dx = (ex - mul_q30(longint'(base_rad), cs)) >>> 8;
			dy = (ey - mul_q30(longint'(base_rad), sn)) >>> 8;
			dz = tz >>> 8;
			sq = dx * dx + dy * dy + dz * dz;
			joint_gap = int_sqrt(sq);
			num = sq + l2 * l2 - l3 * l3;
			den = 2 * joint_gap * l2;
			nabs = num < 0 ? -num : num;
			ok = (den != 0) && (nabs <= den);
			ang = 0;
			if (ok) begin
				q = 0;
				r = nabs;
				if (r >= den) begin
					q = 1; r = r - den;
				end
				for (int i = 0; i < 30; i++) begin
					r = r * 2;
					q = q * 2;
					if (r >= den) begin
						r = r - den; q = q + 1;
					end
				end
				c = num < 0 ? -q : q;
				proj = mul_q30(ex, cs) + mul_q30(ey, sn);
				elev = vector_angle(tz, proj < 0 ? -proj : proj);
				if (proj < 0) elev = elev + Q24_90;
				elev = elev - vector_angle(int_sqrt(64'h1000_0000_0000_0000 - c * c), c);
				ang = (elev + 128) >>> 8;
				if (ang > ANGLE_MAX) ang = ANGLE_MAX;
				if (ang < -ANGLE_MAX) ang = -ANGLE_MAX;
			end
			res.arm = ARM_IDX_W'(s);
			res.angle = ang[ANGLE_W-1:0];
			res.reach = ok;
			res.final_arm = (s == ARMS - 1);
			pending_angles = {pending_angles, res};
		end
	endtask

	// Result side: random short stalls, plus a long hold-off when one is requested.
	initial begin
		arm_result_t want;
		int stall_left;
		int hold_left;
		int hold_seen;
		stall_left = 0;
		hold_left = 0;
		hold_seen = 0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				if (pending_angles.size() == 0) begin
					$error("result beat with nothing expected: arm %0d angle %0d", arm_index,
						angle_deg);
					fails++;
				end else begin
					want = pending_angles.pop_front();
					if (arm_index !== want.arm) begin
						$error("arm_index expected %0d got %0d", want.arm, arm_index);
						fails++;
					end
					if (angle_deg !== want.angle) begin
						$error("angle_deg expected %0d got %0d", want.angle, angle_deg);
						fails++;
					end
					if (reachable !== want.reach) begin
						$error("reachable expected %0d got %0d", want.reach, reachable);
						fails++;
					end
					if (last !== want.final_arm) begin
						$error("last expected %0d got %0d", want.final_arm, last);
						fails++;
					end
				end
			end
			@(negedge clk);
			if (hold_seen != hold_requests) begin
				hold_seen = hold_requests;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (!quiet && !(arst_n === 1'b0) && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(0, 2);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Called just after a falling edge; returns just after a falling edge.
	task automatic send_target(input logic signed [TGT_W-1:0] x, input logic signed [TGT_W-1:0] y,
			input logic signed [TGT_W-1:0] z, input bit out_of_reach);
		arm_result_t res;
		in_valid <= 1'b1;
		target_x <= x;
		target_y <= y;
		target_z <= z;
		do @(posedge clk); while (!in_ready);
		if (out_of_reach) begin
			for (int s = 0; s < ARMS; s++) begin
				res.arm = ARM_IDX_W'(s);
				res.angle = '0;
				res.reach = 1'b0;
				res.final_arm = (s == ARMS - 1);
				pending_angles = {pending_angles, res};
			end
		end else begin
			solve_arm_angles(x, y, z);
		end
		@(negedge clk);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
	endtask

	// Waits out every expected beat and the pipeline depth so the block is idle.
	task automatic drain_block();
		if (in_valid) in_valid <= 1'b0;
		while (pending_angles.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t which, input logic [CFG_DATA_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= which;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		case (which)
			REG_ARM_LENGTH: arm_len = value[LEN_W-1:0];
			REG_ROD_LENGTH: rod_len = value[LEN_W-1:0];
			REG_BASE_RADIUS: base_rad = value[LEN_W-1:0];
			REG_EFFECTOR_RADIUS: eff_rad = value[LEN_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic set_geometry(input logic [31:0] arm_v, input logic [31:0] rod_v,
			input logic [31:0] base_v, input logic [31:0] eff_v);
		drain_block();
		write_reg(REG_ARM_LENGTH, arm_v);
		write_reg(REG_ROD_LENGTH, rod_v);
		write_reg(REG_BASE_RADIUS, base_v);
		write_reg(REG_EFFECTOR_RADIUS, eff_v);
	endtask

	// Mostly targets below the base inside the reach of the arms, some raw 32-bit noise.
	task automatic send_random_targets(input int count);
		int span;
		int lift;
		logic signed [TGT_W-1:0] x, y, z;
		span = (arm_len >> 16) + 10;
		lift = (rod_len >> 16) + 10;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 4) == 0) begin
				x = $urandom;
				y = $urandom;
				z = $urandom;
			end else begin
				x = ($signed($urandom_range(0, 2 * span)) - span) * 65536 + $urandom_range(0, 65535);
				y = ($signed($urandom_range(0, 2 * span)) - span) * 65536 + $urandom_range(0, 65535);
				z = -$signed($urandom_range(lift / 3, lift + span)) * 65536 + $urandom_range(0, 65535);
			end
			send_target(x, y, z, 1'b0);
		end
	endtask

	target_row_t plan[] = '{
		'{32'sd0, 32'sd0, -32'sd9830400, 1'b0},
		'{32'sd0, 32'sd0, 32'sd0, 1'b1},
		'{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1},
		'{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1},
		'{32'sd0, 32'sd0, 32'h8000_0000, 1'b1},
		'{32'sd3276800, 32'sd0, 32'sd0, 1'b0},
		'{-32'sd1966080, 32'sd0, 32'sd0, 1'b0},
		'{-32'sd1966080, 32'sd0, -32'sd9830400, 1'b0},
		'{-32'sd9830400, 32'sd0, -32'sd6553600, 1'b0},
		'{32'sd3276800, 32'sd5242880, 32'sd9830400, 1'b0},
		'{32'sd0, -32'sd4000000, -32'sd13107200, 1'b0},
		'{32'sd1, -32'sd1, -32'sd16000000, 1'b0}
	};

	initial begin
		int arm_mm, rod_mm;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Reset geometry first, then the same values rewritten with bit 31 set on all but the base radius to check masking.
		foreach (plan[i]) send_target(plan[i].x, plan[i].y, plan[i].z, plan[i].out_of_reach);
		set_geometry(32'h8000_0000 | ARM_LENGTH_RST, 32'h8000_0000 | ROD_LENGTH_RST,
			BASE_RADIUS_RST, 32'h8000_0000 | EFFECTOR_RADIUS_RST);
		send_random_targets(6);

		set_geometry(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
		send_target(32'sd0, 32'sd0, 32'sd0, 1'b0);
		send_target(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
		send_random_targets(4);

		set_geometry(32'd1, 32'd1, 32'd1, 32'd0);
		send_target(32'sd0, 32'sd0, 32'sd0, 1'b0);
		send_random_targets(4);

		// Arm shorter than the sub-byte step: denominator is zero, nothing is reachable.
		set_geometry(32'd255, ROD_LENGTH_RST, BASE_RADIUS_RST, EFFECTOR_RADIUS_RST);
		send_target(32'sd0, 32'sd0, -32'sd9830400, 1'b1);

		for (int phase = 0; phase < 4; phase++) begin
			arm_mm = $urandom_range(40, 200);
			rod_mm = arm_mm + $urandom_range(arm_mm / 2, 2 * arm_mm);
			set_geometry(arm_mm * 65536 + $urandom_range(0, 65535),
				rod_mm * 65536 + $urandom_range(0, 65535),
				$urandom_range(20, 120) * 65536 + $urandom_range(0, 65535),
				$urandom_range(0, 60) * 65536 + $urandom_range(0, 65535));
			if (phase == 3) quiet = 1'b1;
			send_random_targets(4);
			// Long hold-off on the result side while enough targets keep coming to fill
			// the pipeline and stall the input.
			if (phase == 1) hold_requests++;
			send_random_targets(phase == 1 ? 56 : 6);
		end

		drain_block();
		if (fails == 0) begin
			$display("parallel_arm_inverse_kinematics verification clean");
		end else begin
			$display("parallel_arm_inverse_kinematics verification failed");
		end
		$finish;
	end

endmodule
